// File: rtl/aso_pkg.sv
`default_nettype none

package aso_pkg;

  typedef enum logic [1:0] {
    OP_SHIFT     = 2'd0,
    OP_IMM_SHIFT = 2'd1,
    OP_EXPAND    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_LSL = 3'd0,
    KIND_LSR = 3'd1,
    KIND_ASR = 3'd2,
    KIND_ROR = 3'd3,
    KIND_RRX = 3'd4
  } kind_e;

  localparam int unsigned DataW   = 32;
  localparam int unsigned AmountW = 8;
  localparam logic [AmountW-1:0] AmountFull = 8'd32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] value;
    logic [2:0]  shift_type;
    logic [7:0]  amount;
    logic [11:0] immediate;
    logic        carry_in;
  } aso_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic        carry_out;
  } aso_out_t;

  // request handed from the decoder to the shifter
  typedef struct packed {
    logic [DataW-1:0]   value;
    logic [2:0]         kind;
    logic [AmountW-1:0] amount;
    logic               carry_in;
    logic               force_zero;
  } shift_req_t;

endpackage

`default_nettype wire

// File: rtl/aso_decode.sv
`default_nettype none

module aso_decode
  import aso_pkg::*;
(
  input  aso_in_t    in_i,
  output shift_req_t req_o
);

  logic [4:0] imm5;
  logic [1:0] enc;

  assign imm5 = in_i.immediate[4:0];
  assign enc  = in_i.shift_type[1:0];

  always_comb begin
    req_o.value      = in_i.value;
    req_o.kind       = in_i.shift_type;
    req_o.amount     = in_i.amount;
    req_o.carry_in   = in_i.carry_in;
    req_o.force_zero = 1'b0;
    case (in_i.operation)
      OP_SHIFT: begin
      end
      OP_IMM_SHIFT: begin
        req_o.amount = {3'b000, imm5};
        case (enc)
          2'd0: req_o.kind = KIND_LSL;
          2'd1: begin
            req_o.kind = KIND_LSR;
            if (imm5 == 5'd0) req_o.amount = AmountFull;
          end
          2'd2: begin
            req_o.kind = KIND_ASR;
            if (imm5 == 5'd0) req_o.amount = AmountFull;
          end
          default: begin
            // ror with a zero immediate encodes rrx
            if (imm5 == 5'd0) begin
              req_o.kind   = KIND_RRX;
              req_o.amount = 8'd1;
            end else begin
              req_o.kind = KIND_ROR;
            end
          end
        endcase
      end
      OP_EXPAND: begin
        req_o.value  = {24'd0, in_i.immediate[7:0]};
        req_o.kind   = KIND_ROR;
        req_o.amount = {3'b000, in_i.immediate[11:8], 1'b0};
      end
      default: req_o.force_zero = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/aso_shifter.sv
`default_nettype none

module aso_shifter
  import aso_pkg::*;
(
  input  shift_req_t req_i,
  output aso_out_t   out_o
);

  logic [31:0] x;
  logic [7:0]  n;
  logic        sign;
  logic        up_to_32;
  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;

  assign x        = req_i.value;
  assign n        = req_i.amount;
  assign sign     = x[31];
  assign up_to_32 = (n <= 8'd32);

  // 33-bit shifts keep the last bit shifted out as the carry
  assign lsl_w = {1'b0, x} << n[5:0];
  assign lsr_w = {x, 1'b0} >> n[5:0];
  assign asr_w = 33'($signed({x, 1'b0}) >>> n[4:0]);
  assign ror_w = {x, x} >> n[4:0];

  always_comb begin
    out_o.result    = 32'd0;
    out_o.carry_out = 1'b0;
    if (req_i.force_zero) begin
      out_o.result    = 32'd0;
      out_o.carry_out = 1'b0;
    end else if (n == 8'd0) begin
      out_o.result    = x;
      out_o.carry_out = req_i.carry_in;
    end else begin
      case (req_i.kind)
        KIND_LSL: begin
          if (up_to_32) begin
            out_o.result    = lsl_w[31:0];
            out_o.carry_out = lsl_w[32];
          end
        end
        KIND_LSR: begin
          if (up_to_32) begin
            out_o.result    = lsr_w[32:1];
            out_o.carry_out = lsr_w[0];
          end
        end
        KIND_ASR: begin
          if (n < 8'd32) begin
            out_o.result    = asr_w[32:1];
            out_o.carry_out = asr_w[0];
          end else begin
            out_o.result    = {32{sign}};
            out_o.carry_out = sign;
          end
        end
        KIND_ROR: begin
          out_o.result    = ror_w[31:0];
          out_o.carry_out = ror_w[31];
        end
        KIND_RRX: begin
          out_o.result    = {req_i.carry_in, x[31:1]};
          out_o.carry_out = x[0];
        end
        default: begin
          out_o.result    = 32'd0;
          out_o.carry_out = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/arm_shifter_operand_unit_core.sv
// start fills the input register, then the result register, which strobes done_o
// throughput: one transaction per cycle, busy_o never rises
// the input register and the result register bound a single shifter pass
// reset clears the valid flags only; no result is lost since the receiver cannot stall
`default_nettype none

module arm_shifter_operand_unit_core
  import aso_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  aso_in_t  in_i,
  output logic     busy_o,
  output logic     done_o,
  output aso_out_t out_o
);

  logic       in_vld_q;
  aso_in_t    in_q;
  logic       res_vld_q;
  aso_out_t   res_q;
  shift_req_t req;
  aso_out_t   res_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) in_q <= in_i;
    if (in_vld_q) res_q <= res_d;
  end

  aso_decode u_decode (
    .in_i  (in_q),
    .req_o (req)
  );

  aso_shifter u_shifter (
    .req_i (req),
    .out_o (res_d)
  );

  assign done_o = res_vld_q;
  assign out_o  = res_q;

endmodule

`default_nettype wire

// File: rtl/aso_checker.sv
`default_nettype none

module aso_checker
  import aso_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input aso_in_t  in_i,
  input logic     busy_o,
  input logic     done_o,
  input aso_out_t out_o
);

  logic [1:0] settle_q;
  logic       settled;

  // settle_q marks when the result pipeline holds real transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'b00;
    end else begin
      settle_q <= {settle_q[0], 1'b1};
    end
  end

  assign settled = settle_q[1];

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_one_per_txn : assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled |-> (done_o == $past(start_i, 2)))
    else $error("result strobe does not match start transaction");

  a_bad_op_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled && $past(start_i, 2) && ($past(in_i.operation, 2) == 2'd3))
      |-> (out_o.result == 32'd0 && !out_o.carry_out))
    else $error("reserved operation gave nonzero result");

  a_zero_shift_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settled && $past(start_i, 2) && ($past(in_i.operation, 2) == OP_SHIFT)
      && ($past(in_i.amount, 2) == 8'd0))
      |-> (out_o.result == $past(in_i.value, 2)
           && out_o.carry_out == $past(in_i.carry_in, 2)))
    else $error("zero shift did not pass operand through");

endmodule

bind arm_shifter_operand_unit_core aso_checker u_aso_checker (.*);

`default_nettype wire
